// File: hdl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants for the point-to-segment distance unit.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int DIST_BITS = 25;

  localparam logic [DIST_BITS-1:0] DIST_ONES = '1;

  localparam logic [1:0] REGION_FOOT = 2'd0;
  localparam logic [1:0] REGION_B    = 2'd1;
  localparam logic [1:0] REGION_A    = 2'd2;

endpackage

// File: hdl/point_segment_distance_unit.sv
// ----------------------------------------------------------------------------
// point_segment_distance_unit
// Pipelined Euclidean distance from a point to a line segment.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the in_ channel carries the point (px, py) and the segment
//   ends A (ax, ay), B (bx, by), signed COORD_WIDTH bits each. One result
//   leaves on the out_ channel per request, in order: distance with
//   FRAC_BITS fraction bits (truncated), region (foot, end B, end A) and a
//   degenerate flag for A equal to B (distance then all ones).
//   Throughput: one request per cycle while the output is not stalled.
//   QW = 2*COORD_WIDTH + 1 + 2*FRAC_BITS is the quotient width of the
//   restoring divider (one bit per stage) and RW = (QW + 1) / 2 is the
//   root width of the square root pipeline (one bit per stage).
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When out_ready is low with a result waiting, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module point_segment_distance_unit
  import psd_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_px,
  input  logic signed [COORD_WIDTH-1:0] in_py,
  input  logic signed [COORD_WIDTH-1:0] in_ax,
  input  logic signed [COORD_WIDTH-1:0] in_ay,
  input  logic signed [COORD_WIDTH-1:0] in_bx,
  input  logic signed [COORD_WIDTH-1:0] in_by,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [DIST_BITS-1:0]          out_distance,
  output logic [1:0]                    out_region,
  output logic                          out_degenerate
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;
  localparam int UW   = SW;
  localparam int DENW = 2 * COORD_WIDTH + 1;
  localparam int LO   = UW / 2;
  localparam int HI   = UW - LO;
  localparam int NUMW = 2 * UW + 2 * FRAC_BITS;
  localparam int QW   = 2 * COORD_WIDTH + 1 + 2 * FRAC_BITS;
  localparam int RMW  = DENW + 1;
  localparam int RW   = (QW + 1) / 2;
  localparam int XW   = 2 * RW;
  localparam int REW  = RW + DIST_BITS;

  logic en;

  // stage 1: differences
  logic                 s1_v_r, s1_degen_r;
  logic signed [DW-1:0] abx_r, aby_r, cax_r, cay_r, cbx_r, cby_r;

  // stage 2: products
  logic                 s2_v_r, s2_degen_r;
  logic signed [PW-1:0] pb0_r, pb1_r, pa0_r, pa1_r, pc0_r, pc1_r;
  logic signed [PW-1:0] qab0_r, qab1_r, qa0_r, qa1_r, qb0_r, qb1_r;

  // stage 3: sums
  logic                 s3_v_r, s3_degen_r, s3_dotb_pos_r, s3_dota_pos_r;
  logic signed [SW-1:0] s3_cross_r;
  logic [DENW-1:0]      s3_den_r, s3_ea_r, s3_eb_r;

  // stage 4: region select
  logic                 s4_v_r, s4_degen_r;
  logic [1:0]           s4_region_r;
  logic [UW-1:0]        s4_uc_r;
  logic [DENW-1:0]      s4_den_r, s4_esel_r;

  // stage 5: partial products of cross squared
  logic                 s5_v_r, s5_degen_r;
  logic [1:0]           s5_region_r;
  logic [2*LO-1:0]      s5_pll_r;
  logic [LO+HI-1:0]     s5_plh_r;
  logic [2*HI-1:0]      s5_phh_r;
  logic [DENW-1:0]      s5_den_r, s5_esel_r;

  // divider
  logic            div_v_r     [0:QW];
  logic            div_degen_r [0:QW];
  logic [1:0]      div_region_r[0:QW];
  logic [RMW-1:0]  div_rem_r   [0:QW];
  logic [QW-1:0]   div_qn_r    [0:QW];
  logic [DENW-1:0] div_den_r   [0:QW];
  logic [RMW-1:0]  div_rem_nxt [1:QW];
  logic [QW-1:0]   div_qn_nxt  [1:QW];

  // square root
  logic            sq_v_r      [0:RW];
  logic            sq_degen_r  [0:RW];
  logic [1:0]      sq_region_r [0:RW];
  logic [RW+1:0]   sq_rem_r    [0:RW];
  logic [RW-1:0]   sq_root_r   [0:RW];
  logic [XW-1:0]   sq_x_r      [0:RW];
  logic [RW+1:0]   sq_rem_nxt  [1:RW];
  logic [RW-1:0]   sq_root_nxt [1:RW];

  logic [2*UW-1:0] usq;
  logic [NUMW-1:0] num;
  logic [REW-1:0]  root_ext;

  assign en       = out_ready | ~out_valid;
  assign in_ready = en;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      for (int k = 0; k <= QW; k++) div_v_r[k] <= 1'b0;
      for (int k = 0; k <= RW; k++) sq_v_r[k] <= 1'b0;
    end else if (en) begin
      s1_v_r     <= in_valid;
      s2_v_r     <= s1_v_r;
      s3_v_r     <= s2_v_r;
      s4_v_r     <= s3_v_r;
      s5_v_r     <= s4_v_r;
      div_v_r[0] <= s5_v_r;
      for (int k = 1; k <= QW; k++) div_v_r[k] <= div_v_r[k-1];
      sq_v_r[0]  <= div_v_r[QW];
      for (int k = 1; k <= RW; k++) sq_v_r[k] <= sq_v_r[k-1];
    end
  end

  // front end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_degen_r <= (in_ax == in_bx) && (in_ay == in_by);
      abx_r      <= DW'(in_bx) - DW'(in_ax);
      aby_r      <= DW'(in_by) - DW'(in_ay);
      cax_r      <= DW'(in_px) - DW'(in_ax);
      cay_r      <= DW'(in_py) - DW'(in_ay);
      cbx_r      <= DW'(in_px) - DW'(in_bx);
      cby_r      <= DW'(in_py) - DW'(in_by);

      s2_degen_r <= s1_degen_r;
      pb0_r      <= abx_r * cbx_r;
      pb1_r      <= aby_r * cby_r;
      pa0_r      <= abx_r * cax_r;
      pa1_r      <= aby_r * cay_r;
      pc0_r      <= abx_r * cay_r;
      pc1_r      <= aby_r * cax_r;
      qab0_r     <= abx_r * abx_r;
      qab1_r     <= aby_r * aby_r;
      qa0_r      <= cax_r * cax_r;
      qa1_r      <= cay_r * cay_r;
      qb0_r      <= cbx_r * cbx_r;
      qb1_r      <= cby_r * cby_r;

      s3_degen_r    <= s2_degen_r;
      s3_dotb_pos_r <= (SW'(pb0_r) + SW'(pb1_r)) > SW'(0);
      s3_dota_pos_r <= (SW'(pa0_r) + SW'(pa1_r)) < SW'(0);
      s3_cross_r    <= SW'(pc0_r) - SW'(pc1_r);
      s3_den_r      <= DENW'($unsigned(qab0_r) + $unsigned(qab1_r));
      s3_ea_r       <= DENW'($unsigned(qa0_r) + $unsigned(qa1_r));
      s3_eb_r       <= DENW'($unsigned(qb0_r) + $unsigned(qb1_r));

      s4_degen_r <= s3_degen_r;
      s4_den_r   <= s3_den_r;
      s4_uc_r    <= s3_cross_r[SW-1] ? UW'(-s3_cross_r) : UW'(s3_cross_r);
      if (s3_dotb_pos_r) begin
        s4_region_r <= REGION_B;
        s4_esel_r   <= s3_eb_r;
      end else if (s3_dota_pos_r) begin
        s4_region_r <= REGION_A;
        s4_esel_r   <= s3_ea_r;
      end else begin
        s4_region_r <= REGION_FOOT;
        s4_esel_r   <= s3_ea_r;
      end

      s5_degen_r  <= s4_degen_r;
      s5_region_r <= s4_region_r;
      s5_den_r    <= s4_den_r;
      s5_esel_r   <= s4_esel_r;
      s5_pll_r    <= (2*LO)'(s4_uc_r[LO-1:0]) * (2*LO)'(s4_uc_r[LO-1:0]);
      s5_plh_r    <= (LO+HI)'(s4_uc_r[LO-1:0]) * (LO+HI)'(s4_uc_r[UW-1:LO]);
      s5_phh_r    <= (2*HI)'(s4_uc_r[UW-1:LO]) * (2*HI)'(s4_uc_r[UW-1:LO]);
    end
  end

  // cross squared and dividend
  always_comb begin
    usq = ((2*UW)'(s5_phh_r) << (2*LO)) + ((2*UW)'(s5_plh_r) << (LO+1))
        + (2*UW)'(s5_pll_r);
    if (s5_region_r == REGION_FOOT) begin
      num = NUMW'(usq) << (2*FRAC_BITS);
    end else begin
      num = NUMW'(s5_esel_r) << (2*FRAC_BITS);
    end
  end

  // restoring divider, one quotient bit per stage
  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      logic [RMW-1:0] t;
      logic           ge;
      t  = {div_rem_r[k-1][RMW-2:0], div_qn_r[k-1][QW-1]};
      ge = t >= {1'b0, div_den_r[k-1]};
      div_rem_nxt[k] = ge ? t - {1'b0, div_den_r[k-1]} : t;
      div_qn_nxt[k]  = {div_qn_r[k-1][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_degen_r[0]  <= s5_degen_r;
      div_region_r[0] <= s5_region_r;
      div_rem_r[0]    <= num[QW +: RMW];
      div_qn_r[0]     <= num[QW-1:0];
      div_den_r[0]    <= (s5_region_r == REGION_FOOT) ? s5_den_r : DENW'(1);
      for (int k = 1; k <= QW; k++) begin
        div_degen_r[k]  <= div_degen_r[k-1];
        div_region_r[k] <= div_region_r[k-1];
        div_den_r[k]    <= div_den_r[k-1];
        div_rem_r[k]    <= div_rem_nxt[k];
        div_qn_r[k]     <= div_qn_nxt[k];
      end
    end
  end

  // integer square root, one root bit per stage
  always_comb begin
    for (int k = 1; k <= RW; k++) begin
      logic [RW+1:0] t;
      logic [RW+1:0] trial;
      logic          ge;
      t     = {sq_rem_r[k-1][RW-1:0], sq_x_r[k-1][XW-1 -: 2]};
      trial = {sq_root_r[k-1], 2'b01};
      ge    = t >= trial;
      sq_rem_nxt[k]  = ge ? t - trial : t;
      sq_root_nxt[k] = {sq_root_r[k-1][RW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_degen_r[0]  <= div_degen_r[QW];
      sq_region_r[0] <= div_region_r[QW];
      sq_x_r[0]      <= XW'(div_qn_r[QW]);
      sq_rem_r[0]    <= '0;
      sq_root_r[0]   <= '0;
      for (int k = 1; k <= RW; k++) begin
        sq_degen_r[k]  <= sq_degen_r[k-1];
        sq_region_r[k] <= sq_region_r[k-1];
        sq_x_r[k]      <= {sq_x_r[k-1][XW-3:0], 2'b00};
        sq_rem_r[k]    <= sq_rem_nxt[k];
        sq_root_r[k]   <= sq_root_nxt[k];
      end
    end
  end

  // output: saturate and degenerate override
  always_comb begin
    root_ext  = REW'(sq_root_r[RW]);
    out_valid = sq_v_r[RW];
    out_degenerate = sq_degen_r[RW];
    if (sq_degen_r[RW]) begin
      out_distance = DIST_ONES;
      out_region   = REGION_FOOT;
    end else begin
      out_distance = ((root_ext >> DIST_BITS) != '0) ? DIST_ONES
                                                     : root_ext[DIST_BITS-1:0];
      out_region   = sq_region_r[RW];
    end
  end

`ifndef SYNTHESIS
  a_degen_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_distance == DIST_ONES && out_region == REGION_FOOT)
    else $error("degenerate result not forced");

  a_degen_detect: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_ax == in_bx && in_ay == in_by |=> s1_degen_r)
    else $error("degenerate segment not flagged");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_region == REGION_FOOT || out_region == REGION_B
                  || out_region == REGION_A)
    else $error("bad region");
`endif

endmodule
